// ===== sv/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Address area codes, result source codes and mapper constants shared by the
// controller and the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

  // The top three address bits split the CPU map into 8 KiB areas.
  typedef enum logic [2:0] {
    AREA_RAM_ENABLE = 3'd0,
    AREA_ROM_BANK   = 3'd1,
    AREA_RAM_BANK   = 3'd2,
    AREA_CLK_LATCH  = 3'd3,
    AREA_VIDEO      = 3'd4,
    AREA_SAVE_RAM   = 3'd5,
    AREA_WORK       = 3'd6,
    AREA_HIGH       = 3'd7
  } area_t;

  typedef enum logic [1:0] {
    SRC_ROM  = 2'd0,
    SRC_DATA = 2'd1,
    SRC_NONE = 2'd2
  } source_t;

  localparam logic [7:0] RAM_ENABLE_KEY  = 8'h0A;
  localparam logic [7:0] RAM_DISABLE_KEY = 8'h00;
  localparam logic [7:0] RAM_SEL_MAX     = 8'h03;
  localparam logic [7:0] CLK_SEL_MIN     = 8'h08;
  localparam logic [7:0] CLK_SEL_MAX     = 8'h0C;
  localparam logic [7:0] DISABLED_BYTE   = 8'hFF;

  localparam int unsigned ROM_BANK_ABITS = 14;  // 16 KiB per ROM bank
  localparam int unsigned RAM_BANK_ABITS = 13;  // 8 KiB per RAM bank
  localparam int unsigned ROM_ADDR_W     = 21;
  localparam int unsigned ROM_SEL_W      = 7;
  localparam int unsigned ROM_SEL_CODES  = 128;

endpackage

`default_nettype wire

// ===== sv/cartridge_bank_controller.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Maps CPU bus accesses onto banked external ROM addresses and an internal
// banked save RAM, and keeps the bank and enable registers of the mapper.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata (low bit up)            tuser
//  -------  ---------  ----------------------------  ---------------
//  in_*     slave      address[15:0], write_data[7:0] func (0 rd, 1 wr)
//  out_*    master     rom_address[20:0], read_data[7:0] source[1:0]
//
//  One access is accepted per cycle while in_tready is high. Its result passes
//  through the RAM stage (the save RAM read) and then the output register.
//  After reset the save RAM is swept to zero, one byte a cycle, through all
//  RAM_BANKS * 8192 bytes (32768 by default); in_tready stays low meanwhile.
//  A stalled output holds the pipeline; after the sweep in_tready drops only
//  when the RAM stage and the output register are full and out_tready is low.
//
`default_nettype none

module cartridge_bank_controller
  import cbc_pkg::*;
#(
  parameter int unsigned RAM_BANKS = 4,
  parameter int unsigned ROM_BANKS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // address[15:0], write_data[23:16]
  input  wire logic [0:0]  in_tuser,   // func[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // rom_address[20:0], read_data[28:21], zero pad
  output logic      [1:0]  out_tuser   // source[1:0]
);

  localparam int unsigned RAM_DEPTH = RAM_BANKS * (2 ** RAM_BANK_ABITS);
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
  localparam int unsigned RAM_BW    = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
  localparam int unsigned ROM_BW    = $clog2(ROM_BANKS);

  typedef logic [ROM_SEL_CODES-1:0][ROM_BW-1:0] rom_tab_t;
  typedef logic [3:0][RAM_BW-1:0]               ram_tab_t;

  // Bank numbers wrap at the configured bank counts; the wrap is folded into
  // the register write through these elaboration-time tables.
  function automatic rom_tab_t build_rom_tab();
    rom_tab_t t;
    for (int i = 0; i < ROM_SEL_CODES; i++) begin
      t[i] = ROM_BW'(i % ROM_BANKS);
    end
    return t;
  endfunction

  function automatic ram_tab_t build_ram_tab();
    ram_tab_t t;
    for (int i = 0; i < 4; i++) begin
      t[i] = RAM_BW'(i % RAM_BANKS);
    end
    return t;
  endfunction

  localparam rom_tab_t ROM_TAB = build_rom_tab();
  localparam ram_tab_t RAM_TAB = build_ram_tab();

  // Input fields
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        is_write;
  area_t       area;

  assign address    = in_tdata[15:0];
  assign write_data = in_tdata[23:16];
  assign is_write   = in_tuser[0];
  assign area       = area_t'(address[15:13]);

  // Mapper registers
  logic [ROM_BW-1:0] rom_bank_r, rom_bank_nxt;
  logic [RAM_BW-1:0] ram_bank_r, ram_bank_nxt;
  logic              ram_en_r, ram_en_nxt;
  logic              ram_mapped_r, ram_mapped_nxt;

  // Clearing sweep
  logic              clearing_r;
  logic [RAM_AW-1:0] clr_addr_r;

  // RAM stage and output register
  logic                  s1_valid_r;
  source_t               s1_src_r;
  logic [ROM_ADDR_W-1:0] s1_rom_addr_r;
  logic                  s1_from_ram_r;
  logic [7:0]            s1_data_r;
  logic                  out_valid_r;
  source_t               out_src_r;
  logic [ROM_ADDR_W-1:0] out_rom_addr_r;
  logic [7:0]            out_data_r;

  logic                  s1_adv;
  logic                  accept;
  source_t               src_nxt;
  logic [ROM_ADDR_W-1:0] rom_addr_nxt;
  logic                  from_ram_nxt;
  logic [7:0]            data_nxt;
  logic [ROM_SEL_W-1:0]  rom_sel_raw;

  logic              ram_we;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !clearing_r && (!s1_valid_r || s1_adv);
  assign accept    = in_tvalid && in_tready;

  // A ROM bank select of zero reads as bank one.
  assign rom_sel_raw = (write_data[ROM_SEL_W-1:0] == '0) ? ROM_SEL_W'(1)
                                                         : write_data[ROM_SEL_W-1:0];

  // Register updates from control-area writes
  always_comb begin
    rom_bank_nxt   = rom_bank_r;
    ram_bank_nxt   = ram_bank_r;
    ram_en_nxt     = ram_en_r;
    ram_mapped_nxt = ram_mapped_r;
    if (accept && is_write) begin
      unique case (area)
        AREA_RAM_ENABLE: begin
          if (write_data == RAM_ENABLE_KEY) begin
            ram_en_nxt = 1'b1;
          end else if (write_data == RAM_DISABLE_KEY) begin
            ram_en_nxt = 1'b0;
          end
        end
        AREA_ROM_BANK: begin
          rom_bank_nxt = ROM_TAB[rom_sel_raw];
        end
        AREA_RAM_BANK: begin
          if (write_data <= RAM_SEL_MAX) begin
            ram_mapped_nxt = 1'b1;
            ram_bank_nxt   = RAM_TAB[write_data[1:0]];
          end else if (write_data >= CLK_SEL_MIN && write_data <= CLK_SEL_MAX) begin
            ram_mapped_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the accepted access, before the RAM data is known
  always_comb begin
    src_nxt      = SRC_NONE;
    rom_addr_nxt = '0;
    from_ram_nxt = 1'b0;
    data_nxt     = '0;
    if (!is_write) begin
      unique case (area)
        AREA_RAM_ENABLE, AREA_ROM_BANK: begin
          src_nxt      = SRC_ROM;
          rom_addr_nxt = ROM_ADDR_W'(address);
        end
        AREA_RAM_BANK, AREA_CLK_LATCH: begin
          src_nxt      = SRC_ROM;
          rom_addr_nxt = ROM_ADDR_W'({rom_bank_r, address[ROM_BANK_ABITS-1:0]});
        end
        AREA_SAVE_RAM: begin
          src_nxt      = SRC_DATA;
          from_ram_nxt = ram_en_r;
          data_nxt     = DISABLED_BYTE;
        end
        default: begin
        end
      endcase
    end
  end

  // Save RAM port: the clearing sweep owns it until done. Reads ignore the
  // mapped flag, writes need it.
  always_comb begin
    ram_addr  = RAM_AW'({ram_bank_r, address[RAM_BANK_ABITS-1:0]});
    ram_wdata = write_data;
    ram_we    = accept && is_write && (area == AREA_SAVE_RAM) && ram_en_r && ram_mapped_r;
    ram_re    = accept && !is_write && (area == AREA_SAVE_RAM) && ram_en_r;
    if (clearing_r) begin
      ram_addr  = clr_addr_r;
      ram_wdata = '0;
      ram_we    = 1'b1;
      ram_re    = 1'b0;
    end
  end

  cbc_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH),
    .AW   (RAM_AW)
  ) u_save_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r   <= ROM_BW'(1);
      ram_bank_r   <= '0;
      ram_en_r     <= 1'b0;
      ram_mapped_r <= 1'b1;
      clearing_r   <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rom_bank_r   <= rom_bank_nxt;
      ram_bank_r   <= ram_bank_nxt;
      ram_en_r     <= ram_en_nxt;
      ram_mapped_r <= ram_mapped_nxt;
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + RAM_AW'(1);
        if (clr_addr_r == RAM_AW'(RAM_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src_r      <= src_nxt;
      s1_rom_addr_r <= rom_addr_nxt;
      s1_from_ram_r <= from_ram_nxt;
      s1_data_r     <= data_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_src_r      <= s1_src_r;
      out_rom_addr_r <= s1_rom_addr_r;
      out_data_r     <= s1_from_ram_r ? ram_rdata : s1_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r, out_rom_addr_r};
  assign out_tuser  = out_src_r;

endmodule

`default_nettype wire

// ===== sv/cbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read, one write or both per cycle at one address; read data is
// registered and holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller testbench
// Sends CPU bus reads and writes through the input stream and keeps its own
// model of the bank registers and the save RAM. Each returned result is
// checked against the oldest prediction. Traffic includes directed corner
// accesses, then random traffic under several sender and receiver idle mixes,
// and a long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_top;
  import cbc_pkg::*;

  typedef struct {
    logic        is_write;
    logic [15:0] address;
    logic [7:0]  wdata;
  } bus_access_t;

  typedef struct {
    source_t     source;
    logic [20:0] rom_address;
    logic [7:0]  read_data;
  } bank_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  cartridge_bank_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mapper state as the CPU should see it.
  logic [6:0] rom_bank_q;
  logic [1:0] ram_bank_q;
  logic       ram_on;
  logic       ram_mapped;
  logic [7:0] save_mem [0:32767];

  bus_access_t  access_q [$];
  bank_result_t result_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int errors = 0;

  function automatic bank_result_t mbc_access(input logic is_write,
                                              input logic [15:0] address,
                                              input logic [7:0] wdata);
    bank_result_t r;
    area_t        area;
    logic [14:0]  idx;
    r.source = SRC_NONE;
    r.rom_address = '0;
    r.read_data = '0;
    area = area_t'(address[15:13]);
    idx = {ram_bank_q, address[12:0]};
    if (is_write) begin
      case (area)
        AREA_RAM_ENABLE: begin
          if (wdata == RAM_ENABLE_KEY) ram_on = 1'b1;
          else if (wdata == RAM_DISABLE_KEY) ram_on = 1'b0;
        end
        AREA_ROM_BANK: begin
          rom_bank_q = (wdata[6:0] == 7'd0) ? 7'd1 : wdata[6:0];
        end
        AREA_RAM_BANK: begin
          if (wdata <= RAM_SEL_MAX) begin
            ram_mapped = 1'b1;
            ram_bank_q = wdata[1:0];
          end else if (wdata >= CLK_SEL_MIN && wdata <= CLK_SEL_MAX) begin
            ram_mapped = 1'b0;
          end
        end
        AREA_SAVE_RAM: begin
          if (ram_on && ram_mapped) save_mem[idx] = wdata;
        end
        default: ;
      endcase
    end else begin
      case (area)
        AREA_RAM_ENABLE, AREA_ROM_BANK: begin
          r.source = SRC_ROM;
          r.rom_address = {5'd0, address};
        end
        AREA_RAM_BANK, AREA_CLK_LATCH: begin
          r.source = SRC_ROM;
          r.rom_address = {rom_bank_q, address[13:0]};
        end
        AREA_SAVE_RAM: begin
          // A selected clock register does not hide the RAM byte from reads.
          r.source = SRC_DATA;
          r.read_data = ram_on ? save_mem[idx] : DISABLED_BYTE;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic queue_access(input logic is_write, input logic [15:0] address,
                              input logic [7:0] wdata);
    bus_access_t a;
    a.is_write = is_write;
    a.address = address;
    a.wdata = wdata;
    access_q.push_back(a);
  endtask

  // Mostly well-formed mapper traffic, clustered on a few RAM offsets so that
  // reads hit bytes written earlier, plus some fully random accesses.
  function automatic bus_access_t random_access();
    bus_access_t a;
    int          pick;
    int          key;
    logic [12:0] offs;
    pick = $urandom_range(99);
    key = $urandom_range(99);
    offs = ($urandom_range(1) == 0) ? 13'($urandom_range(15)) : 13'($urandom);
    a.wdata = 8'($urandom);
    a.address = 16'($urandom);
    a.is_write = 1'b1;
    if (pick < 10) begin
      a.address = {AREA_RAM_ENABLE, 13'($urandom)};
      if (key < 60) a.wdata = RAM_ENABLE_KEY;
      else if (key < 80) a.wdata = RAM_DISABLE_KEY;
    end else if (pick < 18) begin
      a.address = {AREA_ROM_BANK, 13'($urandom)};
    end else if (pick < 28) begin
      a.address = {AREA_RAM_BANK, 13'($urandom)};
      if (key < 60) a.wdata = 8'($urandom_range(3));
      else if (key < 80) a.wdata = 8'($urandom_range(CLK_SEL_MAX, CLK_SEL_MIN));
    end else if (pick < 50) begin
      a.address = {AREA_SAVE_RAM, offs};
    end else if (pick < 75) begin
      a.is_write = 1'b0;
      a.address = {AREA_SAVE_RAM, offs};
    end else if (pick < 88) begin
      a.is_write = 1'b0;
      a.address = {1'b0, 15'($urandom)};
    end else begin
      a.is_write = 1'($urandom);
    end
    return a;
  endfunction

  // Checked on the falling edge, once the driver and monitor have settled.
  task automatic wait_idle();
    @(negedge clk);
    while (access_q.size() != 0 || in_tvalid || result_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  // Driver: a transfer completes on an edge with valid and ready both high.
  always @(posedge clk) begin
    bus_access_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        result_q.push_back(mbc_access(in_tuser[0], in_tdata[15:0], in_tdata[23:16]));
      if (!in_tvalid || in_tready) begin
        if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = access_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {nxt.wdata, nxt.address};
          in_tuser <= nxt.is_write;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Monitor and checker.
  always @(posedge clk) begin
    bank_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t ns: result transfer with nothing expected", $time);
        end else begin
          want = result_q.pop_front();
          if (out_tuser !== want.source)
            report_mismatch("source", 32'(out_tuser), 32'(want.source));
          if (out_tdata[20:0] !== want.rom_address)
            report_mismatch("rom_address", 32'(out_tdata[20:0]), 32'(want.rom_address));
          if (out_tdata[28:21] !== want.read_data)
            report_mismatch("read_data", 32'(out_tdata[28:21]), 32'(want.read_data));
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rom_bank_q = 7'd1;
    ram_bank_q = 2'd0;
    ram_on = 1'b0;
    ram_mapped = 1'b1;
    for (int i = 0; i < 32768; i++) save_mem[i] = 8'h00;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners; the save RAM sweep after reset holds these back.
    queue_access(1'b0, 16'h0000, 8'h00);
    queue_access(1'b0, 16'h3FFF, 8'hFF);
    queue_access(1'b0, 16'h4000, 8'h00);
    queue_access(1'b0, 16'hA000, 8'h00);  // RAM still disabled
    queue_access(1'b1, 16'h0000, RAM_ENABLE_KEY);
    queue_access(1'b0, 16'hBFFF, 8'h00);  // cleared by reset
    queue_access(1'b1, 16'hA000, 8'h5A);
    queue_access(1'b1, 16'hBFFF, 8'hA5);
    queue_access(1'b0, 16'hA000, 8'h00);
    queue_access(1'b1, 16'h3FFF, 8'hFF);
    queue_access(1'b0, 16'h7FFF, 8'h00);
    queue_access(1'b1, 16'h2000, 8'h80);  // bank zero reads as bank one
    queue_access(1'b0, 16'h5555, 8'h00);
    queue_access(1'b1, 16'h4000, 8'h03);
    queue_access(1'b1, 16'hA123, 8'h77);
    queue_access(1'b1, 16'h5FFF, CLK_SEL_MIN);
    queue_access(1'b1, 16'hA123, 8'h11);  // dropped while a clock is selected
    queue_access(1'b0, 16'hA123, 8'h00);
    queue_access(1'b1, 16'h4000, 8'h07);  // unused select value
    queue_access(1'b1, 16'h4000, 8'h0D);
    queue_access(1'b1, 16'h4000, CLK_SEL_MAX);
    queue_access(1'b1, 16'h1FFF, 8'h55);  // neither enable nor disable key
    queue_access(1'b1, 16'h6000, 8'h01);
    queue_access(1'b0, 16'h8000, 8'h00);
    queue_access(1'b0, 16'hFFFF, 8'h00);
    queue_access(1'b1, 16'h1000, RAM_DISABLE_KEY);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      send_idle_pct <= (ph == 1 || ph == 3) ? ((ph == 1) ? 73 : 29) : 0;
      recv_stall_pct <= (ph == 2 || ph == 3) ? ((ph == 2) ? 73 : 29) : 0;
      for (int i = 0; i < 200; i++) access_q.push_back(random_access());
      wait_idle();
    end

    // Receiver holds off while the sender keeps offering transfers.
    @(posedge clk);
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    hold_left <= 300;
    for (int i = 0; i < 60; i++) access_q.push_back(random_access());
    wait_idle();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
